// ===== rtl/gaussian_splat_grid_macros.svh =====
// assertion helpers used by the grid top module
`ifndef GAUSSIAN_SPLAT_GRID_MACROS_SVH
`define GAUSSIAN_SPLAT_GRID_MACROS_SVH

// same-cycle implication, checked outside reset
`define GSG_ASSERT_NOW(label, clk_sig, rst_n_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define GSG_ASSERT_NEXT(label, clk_sig, rst_n_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/gsg_pkg.sv =====
`default_nettype none

package gsg_pkg;

    localparam int CELL_W  = 7;
    localparam int COORD_W = 8;
    localparam int OFF_W   = 4;
    localparam int RAD_W   = 3;
    localparam int D2_W    = 7;
    localparam int WGT_W   = 17;
    localparam int PROD_W  = 24;

    localparam logic [6:0] RST_GRID_WIDTH    = 7'd40;
    localparam logic [6:0] RST_GRID_HEIGHT   = 7'd40;
    localparam logic [1:0] RST_KERNEL_RADIUS = 2'd3;
    localparam logic [6:0] RST_PEAK_LEVEL    = 7'd100;

    localparam logic [1:0] CFG_GRID_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_GRID_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_KERNEL_RADIUS = 2'd2;
    localparam logic [1:0] CFG_PEAK_LEVEL    = 2'd3;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_SPLAT = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLAT,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [6:0] grid_width;
        logic [6:0] grid_height;
        logic [1:0] kernel_radius;
        logic [6:0] peak_level;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } splat_status_t;

    // square of an offset magnitude
    function automatic logic [5:0] offset_sq(input logic [2:0] mag);
        logic [5:0] sq;
        case (mag)
            3'd0:    sq = 6'd0;
            3'd1:    sq = 6'd1;
            3'd2:    sq = 6'd4;
            3'd3:    sq = 6'd9;
            3'd4:    sq = 6'd16;
            3'd5:    sq = 6'd25;
            3'd6:    sq = 6'd36;
            default: sq = 6'd49;
        endcase
        return sq;
    endfunction

    // round(65536 * exp(-d2/2)), zero from d2 = 24 on
    function automatic logic [WGT_W-1:0] weight_q16(input logic [D2_W-1:0] d2);
        logic [WGT_W-1:0] w;
        case (d2)
            7'd0:    w = 17'd65536;
            7'd1:    w = 17'd39750;
            7'd2:    w = 17'd24109;
            7'd3:    w = 17'd14623;
            7'd4:    w = 17'd8869;
            7'd5:    w = 17'd5380;
            7'd6:    w = 17'd3263;
            7'd7:    w = 17'd1979;
            7'd8:    w = 17'd1200;
            7'd9:    w = 17'd728;
            7'd10:   w = 17'd442;
            7'd11:   w = 17'd268;
            7'd12:   w = 17'd162;
            7'd13:   w = 17'd99;
            7'd14:   w = 17'd60;
            7'd15:   w = 17'd36;
            7'd16:   w = 17'd22;
            7'd17:   w = 17'd13;
            7'd18:   w = 17'd8;
            7'd19:   w = 17'd5;
            7'd20:   w = 17'd3;
            7'd21:   w = 17'd2;
            7'd22:   w = 17'd1;
            7'd23:   w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gaussian_splat_grid.sv =====
// a clear sweeps 2^ADDR_W cells, one cell per cycle; a splat walks (2r+1)^2 offsets
// (r the clipped kernel radius); a read goes by ST_READ, an unused command to ST_DONE
// throughput: one item at a time; a splat walks one kernel offset per cycle
// reset: config registers load their defaults, then a clear pass over 2^ADDR_W cells
// zeroes the grid with in_ready low; config beats wait for idle with no item offered
`default_nettype none

`include "gaussian_splat_grid_macros.svh"

module gaussian_splat_grid #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 3
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // item channel
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [1:0] cmd,
    input  wire logic [5:0] center_col,
    input  wire logic [5:0] center_row,
    // result channel
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [6:0] cell_value,
    // config write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [1:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    localparam int GRID_CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = $clog2(GRID_CELLS);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'((2 ** ADDR_W) - 1);

    // control state
    gsg_pkg::state_t       state_reg, state_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic                  clr_resp_reg, clr_resp_next;
    logic                  out_valid_reg, out_valid_next;
    gsg_pkg::cfg_t         cfg_reg, cfg_next;
    // payload
    logic [6:0]            res_reg, res_next;
    logic                  rd_hit_reg, rd_hit_next;
    logic [6:0]            cell_value_reg, cell_value_next;

    // grid memory ports
    logic                       mem_wr_en;
    logic [ADDR_W-1:0]          mem_wr_addr;
    logic [gsg_pkg::CELL_W-1:0] mem_wr_data;
    logic                       mem_rd_en;
    logic [ADDR_W-1:0]          mem_rd_addr;
    logic [gsg_pkg::CELL_W-1:0] mem_rd_data;

    // splat unit
    logic                       spl_start;
    logic                       spl_rd_en;
    logic [ADDR_W-1:0]          spl_rd_addr;
    logic                       spl_wr_en;
    logic [ADDR_W-1:0]          spl_wr_addr;
    logic [gsg_pkg::CELL_W-1:0] spl_wr_data;
    gsg_pkg::splat_status_t     spl_status;

    // direct read of one cell
    logic                       rd_hit;
    logic [ADDR_W-1:0]          rd_cell_addr;

    gsg_grid_mem #(
        .DEPTH (2 ** ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    gsg_splat_unit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_RADIUS (MAX_RADIUS)
    ) u_splat (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (spl_start),
        .center_col (center_col),
        .center_row (center_row),
        .cfg        (cfg_reg),
        .rd_en      (spl_rd_en),
        .rd_addr    (spl_rd_addr),
        .rd_data    (mem_rd_data),
        .wr_en      (spl_wr_en),
        .wr_addr    (spl_wr_addr),
        .wr_data    (spl_wr_data),
        .status     (spl_status)
    );

    assign in_ready   = (state_reg == gsg_pkg::ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign cell_value = cell_value_reg;
    // no config beat while an item runs or is being offered
    assign cfg_ready  = (state_reg == gsg_pkg::ST_IDLE) && !in_valid;

    // a read outside the rows or columns in use returns zero
    always_comb
    begin
        rd_hit = ({1'b0, center_col} < cfg_reg.grid_width) && (int'(center_col) < MAX_WIDTH)
              && ({1'b0, center_row} < cfg_reg.grid_height) && (int'(center_row) < MAX_HEIGHT);
        rd_cell_addr = ADDR_W'(center_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(center_col);
    end

    // config registers, written only while idle
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gsg_pkg::CFG_GRID_WIDTH:    cfg_next.grid_width    = cfg_data;
                gsg_pkg::CFG_GRID_HEIGHT:   cfg_next.grid_height   = cfg_data;
                gsg_pkg::CFG_KERNEL_RADIUS: cfg_next.kernel_radius = cfg_data[1:0];
                gsg_pkg::CFG_PEAK_LEVEL:    cfg_next.peak_level    = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // sequencer: owns the memory ports except while a splat runs
    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        clr_resp_next   = clr_resp_reg;
        res_next        = res_reg;
        rd_hit_next     = rd_hit_reg;
        cell_value_next = cell_value_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        spl_start       = 1'b0;
        mem_wr_en       = spl_wr_en;
        mem_wr_addr     = spl_wr_addr;
        mem_wr_data     = spl_wr_data;
        mem_rd_en       = spl_rd_en;
        mem_rd_addr     = spl_rd_addr;

        unique case (state_reg)
            gsg_pkg::ST_CLEAR:
            begin
                // sweep one cell per cycle
                mem_wr_en     = 1'b1;
                mem_wr_addr   = clr_addr_reg;
                mem_wr_data   = '0;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == CLR_LAST)
                begin
                    res_next   = '0;
                    state_next = clr_resp_reg ? gsg_pkg::ST_DONE : gsg_pkg::ST_IDLE;
                end
            end
            gsg_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (gsg_pkg::cmd_t'(cmd))
                        gsg_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            clr_resp_next = 1'b1;
                            state_next    = gsg_pkg::ST_CLEAR;
                        end
                        gsg_pkg::CMD_SPLAT:
                        begin
                            spl_start  = 1'b1;
                            state_next = gsg_pkg::ST_SPLAT;
                        end
                        gsg_pkg::CMD_READ:
                        begin
                            mem_rd_en   = rd_hit;
                            mem_rd_addr = rd_cell_addr;
                            rd_hit_next = rd_hit;
                            state_next  = gsg_pkg::ST_READ;
                        end
                        default:
                        begin
                            // unused command: zero acknowledge only
                            res_next   = '0;
                            state_next = gsg_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            gsg_pkg::ST_SPLAT:
            begin
                if (spl_status.done)
                begin
                    res_next   = '0;
                    state_next = gsg_pkg::ST_DONE;
                end
            end
            gsg_pkg::ST_READ:
            begin
                res_next   = rd_hit_reg ? mem_rd_data : '0;
                state_next = gsg_pkg::ST_DONE;
            end
            gsg_pkg::ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    cell_value_next = res_reg;
                    state_next      = gsg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gsg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gsg_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cfg_reg       <= '{grid_width:    gsg_pkg::RST_GRID_WIDTH,
                               grid_height:   gsg_pkg::RST_GRID_HEIGHT,
                               kernel_radius: gsg_pkg::RST_KERNEL_RADIUS,
                               peak_level:    gsg_pkg::RST_PEAK_LEVEL};
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg        <= res_next;
        rd_hit_reg     <= rd_hit_next;
        cell_value_reg <= cell_value_next;
    end

    // the splat pipeline never reads the cell it writes back in the same cycle
    `GSG_ASSERT_NOW(a_no_rw_same_cell, clk, rst_n, mem_rd_en && mem_wr_en, mem_rd_addr != mem_wr_addr, "grid read and write hit the same cell")
    // the splat unit only runs while the sequencer has handed it the memory
    `GSG_ASSERT_NOW(a_splat_owns_mem, clk, rst_n, spl_status.busy || spl_status.done, state_reg == gsg_pkg::ST_SPLAT, "splat unit active outside splat state")
    // a clearing sweep keeps going until its last cell
    `GSG_ASSERT_NEXT(a_clear_runs_out, clk, rst_n, (state_reg == gsg_pkg::ST_CLEAR) && (clr_addr_reg != CLR_LAST), state_reg == gsg_pkg::ST_CLEAR, "clearing sweep cut short")
    // results only come out of the done state
    `GSG_ASSERT_NOW(a_result_from_done, clk, rst_n, $rose(out_valid_reg), $past(state_reg) == gsg_pkg::ST_DONE, "result beat without completed item")

endmodule

`default_nettype wire

// ===== rtl/gsg_grid_mem.sv =====
`default_nettype none

module gsg_grid_mem #(
    parameter int DEPTH = 4096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic [gsg_pkg::CELL_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic      [gsg_pkg::CELL_W-1:0] rd_data
);

    logic [gsg_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gsg_splat_unit.sv =====
`default_nettype none

module gsg_splat_unit #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int MAX_RADIUS = 3,
    localparam int ADDR_W = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [5:0]                 center_col,
    input  wire logic [5:0]                 center_row,
    input  wire gsg_pkg::cfg_t              cfg,
    output logic                            rd_en,
    output logic      [ADDR_W-1:0]          rd_addr,
    input  wire logic [gsg_pkg::CELL_W-1:0] rd_data,
    output logic                            wr_en,
    output logic      [ADDR_W-1:0]          wr_addr,
    output logic      [gsg_pkg::CELL_W-1:0] wr_data,
    output gsg_pkg::splat_status_t          status
);

    // walk state
    logic                              active_reg, active_next;
    logic signed [gsg_pkg::OFF_W-1:0]  dx_reg, dx_next;
    logic signed [gsg_pkg::OFF_W-1:0]  dy_reg, dy_next;
    logic signed [gsg_pkg::OFF_W-1:0]  rad_reg, rad_next;
    logic        [5:0]                 col_reg, col_next;
    logic        [5:0]                 row_reg, row_next;
    logic                              done_reg, done_next;
    // write-back stage
    logic                              wb_valid_reg, wb_valid_next;
    logic        [ADDR_W-1:0]          wb_addr_reg, wb_addr_next;
    logic        [gsg_pkg::CELL_W-1:0] add_reg, add_next;

    logic        [gsg_pkg::RAD_W-1:0]   rad_eff;
    logic signed [gsg_pkg::OFF_W-1:0]   rad_s;
    logic signed [gsg_pkg::COORD_W-1:0] c_s;
    logic signed [gsg_pkg::COORD_W-1:0] r_s;
    logic                               in_grid;
    logic        [ADDR_W-1:0]           addr;
    logic        [2:0]                  dx_mag;
    logic        [2:0]                  dy_mag;
    logic        [gsg_pkg::D2_W-1:0]    d2;
    logic        [gsg_pkg::PROD_W-1:0]  prod;
    logic                               last_step;
    logic        [gsg_pkg::CELL_W:0]    sum;

    always_comb
    begin
        if (int'(cfg.kernel_radius) > MAX_RADIUS)
        begin
            rad_eff = gsg_pkg::RAD_W'(MAX_RADIUS);
        end
        else
        begin
            rad_eff = {1'b0, cfg.kernel_radius};
        end
        rad_s = signed'({1'b0, rad_eff});
    end

    // target cell of the current offset
    always_comb
    begin
        c_s = signed'({2'b00, col_reg}) + gsg_pkg::COORD_W'(dx_reg);
        r_s = signed'({2'b00, row_reg}) + gsg_pkg::COORD_W'(dy_reg);
        in_grid = !c_s[gsg_pkg::COORD_W-1] && !r_s[gsg_pkg::COORD_W-1]
                && (c_s[6:0] < cfg.grid_width) && (int'(c_s[6:0]) < MAX_WIDTH)
                && (r_s[6:0] < cfg.grid_height) && (int'(r_s[6:0]) < MAX_HEIGHT);
        addr = ADDR_W'(r_s[6:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c_s[6:0]);
    end

    // kernel weight times peak, fraction dropped
    always_comb
    begin
        dx_mag = dx_reg[gsg_pkg::OFF_W-1] ? 3'(-dx_reg) : dx_reg[2:0];
        dy_mag = dy_reg[gsg_pkg::OFF_W-1] ? 3'(-dy_reg) : dy_reg[2:0];
        d2 = gsg_pkg::D2_W'(gsg_pkg::offset_sq(dx_mag))
           + gsg_pkg::D2_W'(gsg_pkg::offset_sq(dy_mag));
        prod = gsg_pkg::PROD_W'(cfg.peak_level) * gsg_pkg::PROD_W'(gsg_pkg::weight_q16(d2));
    end

    always_comb
    begin
        last_step = (dx_reg == rad_reg) && (dy_reg == rad_reg);

        active_next   = active_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        rad_next      = rad_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        done_next     = active_reg && last_step;
        wb_valid_next = active_reg && in_grid;
        wb_addr_next  = addr;
        add_next      = prod[gsg_pkg::CELL_W+15:16];

        if (start)
        begin
            active_next = 1'b1;
            rad_next    = rad_s;
            dx_next     = -rad_s;
            dy_next     = -rad_s;
            col_next    = center_col;
            row_next    = center_row;
        end
        else if (active_reg)
        begin
            if (dx_reg == rad_reg)
            begin
                dx_next = -rad_reg;
                if (dy_reg == rad_reg)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    dy_next = dy_reg + 1'b1;
                end
            end
            else
            begin
                dx_next = dx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            wb_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            active_reg   <= active_next;
            wb_valid_reg <= wb_valid_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        rad_reg     <= rad_next;
        col_reg     <= col_next;
        row_reg     <= row_next;
        wb_addr_reg <= wb_addr_next;
        add_reg     <= add_next;
    end

    // read now, add and clamp when the data returns
    always_comb
    begin
        rd_en   = active_reg && in_grid;
        rd_addr = addr;
        sum     = {1'b0, rd_data} + {1'b0, add_reg};
        wr_en   = wb_valid_reg;
        wr_addr = wb_addr_reg;
        wr_data = (sum > {1'b0, cfg.peak_level}) ? cfg.peak_level : sum[gsg_pkg::CELL_W-1:0];
        status.busy = active_reg || wb_valid_reg;
        status.done = done_reg;
    end

endmodule

`default_nettype wire

// ===== verif/gaussian_splat_grid_test.sv =====
`default_nettype none

module gaussian_splat_grid_test;

    timeunit 1ns;
    timeprecision 1ps;

    import gsg_pkg::*;

    // grid bounds of the default build
    localparam int GRID_MAX_COLS = 64;
    localparam int GRID_MAX_ROWS = 64;

    // command code the block leaves unused
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // gaussian falloff exp(-d2/2) in unsigned q1.16, indexed by squared distance;
    // a radius of 3 reaches at most d2 = 18
    localparam int unsigned GAUSS_Q16 [0:18] = '{
        65536, 39750, 24109, 14623, 8869, 5380, 3263, 1979, 1200, 728,
        442, 268, 162, 99, 60, 36, 22, 13, 8
    };

    // one accepted item together with the cell value it must return
    typedef struct {
        logic [1:0] op;
        logic [5:0] col;
        logic [5:0] row;
        logic [6:0] value;
    } cell_beat_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] cmd;
    logic [5:0] center_col;
    logic [5:0] center_row;
    logic       out_valid;
    logic       out_ready;
    logic [6:0] cell_value;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    // shadow of the cost grid and of the config registers
    logic [6:0] cost_cells [0:GRID_MAX_COLS*GRID_MAX_ROWS-1];
    logic [6:0] grid_cols;
    logic [6:0] grid_rows;
    logic [1:0] splat_radius;
    logic [6:0] peak;

    // cell values still owed by the block, oldest first
    cell_beat_t pending_cells [$];

    // recent splat centres, so that reads land where cells have content
    logic [5:0] hot_col [0:3];
    logic [5:0] hot_row [0:3];

    // random idling on both channels
    bit pace_on;

    int err_count;
    int n_items;
    int n_splats;
    int n_reads;
    int n_clears;
    int n_unused;
    int n_grid_sets;

    gaussian_splat_grid dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .cmd        (cmd),
        .center_col (center_col),
        .center_row (center_row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cell_value (cell_value),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("** gaussian_splat_grid: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    function automatic int cols_in_use();
        return (grid_cols > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(grid_cols);
    endfunction

    function automatic int rows_in_use();
        return (grid_rows > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(grid_rows);
    endfunction

    function automatic void wipe_cells();
        foreach (cost_cells[i])
            cost_cells[i] = '0;
    endfunction

    // stamp the kernel around (col, row); each touched cell saturates at the peak,
    // which also pulls down cells left above a lowered ceiling
    function automatic void stamp_kernel(int col, int row);
        int          r;
        int          c;
        int          rr;
        int          d2;
        int unsigned gain;
        int unsigned sum;
        r = int'(splat_radius);
        for (int dy = -r; dy <= r; dy++)
        begin
            for (int dx = -r; dx <= r; dx++)
            begin
                c  = col + dx;
                rr = row + dy;
                if (c >= 0 && c < cols_in_use() && rr >= 0 && rr < rows_in_use())
                begin
                    d2   = dx * dx + dy * dy;
                    gain = (int'(peak) * GAUSS_Q16[d2]) >> 16;
                    sum  = cost_cells[rr * GRID_MAX_COLS + c] + gain;
                    cost_cells[rr * GRID_MAX_COLS + c] = (sum > peak) ? peak : sum[6:0];
                end
            end
        end
    endfunction

    // applies one item to the shadow grid and returns the cell value it yields
    function automatic logic [6:0] predict_cell_value(logic [1:0] op, logic [5:0] col,
                                                      logic [5:0] row);
        logic [6:0] value;
        value = '0;
        case (op)
            CMD_CLEAR: wipe_cells();
            CMD_SPLAT: stamp_kernel(int'(col), int'(row));
            CMD_READ:
            begin
                if (col < cols_in_use() && row < rows_in_use())
                    value = cost_cells[int'(row) * GRID_MAX_COLS + int'(col)];
            end
            default: value = '0;
        endcase
        return value;
    endfunction

    // ---------------------------------------------------------------
    // result checker
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin : check_results
        cell_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_cells.size() == 0)
            begin
                $error("cell_value beat with nothing outstanding: got %0d", cell_value);
                err_count++;
            end
            else
            begin
                want = pending_cells.pop_front();
                if (cell_value !== want.value)
                begin
                    $error("cell_value (cmd %0d col %0d row %0d): expected %0d, actual %0d",
                           want.op, want.col, want.row, want.value, cell_value);
                    err_count++;
                end
            end
        end
    end

    // result side: random stall bursts while pacing is on
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pace_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    // one item beat; valid is left high so back-to-back beats need no dip,
    // settle_grid() lowers it once a sequence is done
    task automatic send_item(logic [1:0] op, logic [5:0] col, logic [5:0] row);
        cell_beat_t b;
        if (pace_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= op;
        center_col <= col;
        center_row <= row;
        do
            @(posedge clk);
        while (!in_ready);
        b.op    = op;
        b.col   = col;
        b.row   = row;
        b.value = predict_cell_value(op, col, row);
        pending_cells.push_back(b);
        n_items++;
        case (op)
            CMD_CLEAR: n_clears++;
            CMD_SPLAT: n_splats++;
            CMD_READ:  n_reads++;
            default:   n_unused++;
        endcase
    endtask

    // stop sending and wait until every owed cell value has come back
    task automatic settle_grid();
        in_valid <= 1'b0;
        while (pending_cells.size() != 0)
            @(posedge clk);
    endtask

    // one register beat, valid stays high for the next one
    task automatic put_reg(logic [1:0] idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_GRID_WIDTH:    grid_cols    = data;
            CFG_GRID_HEIGHT:   grid_rows    = data;
            CFG_KERNEL_RADIUS: splat_radius = data[1:0];
            default:           peak         = data;
        endcase
    endtask

    // write all four registers; only called with nothing in flight
    task automatic set_grid(logic [6:0] w, logic [6:0] h, logic [6:0] r, logic [6:0] p);
        put_reg(CFG_GRID_WIDTH, w);
        put_reg(CFG_GRID_HEIGHT, h);
        put_reg(CFG_KERNEL_RADIUS, r);
        put_reg(CFG_PEAK_LEVEL, p);
        cfg_valid <= 1'b0;
        n_grid_sets++;
    endtask

    // coordinate biased towards the cells in use, with a tail over the full field
    function automatic logic [5:0] pick_coord(int span);
        if ($urandom_range(0, 7) == 0)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(0, (span + 2 > 63) ? 63 : span + 2));
    endfunction

    // coordinate within three cells of a given one, kept on the field
    function automatic logic [5:0] near_coord(logic [5:0] base);
        int v;
        v = int'(base) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 63)
            v = 63;
        return 6'(v);
    endfunction

    // random register set: mostly small dense grids, now and then an extreme
    task automatic pick_random_grid();
        logic [6:0] w;
        logic [6:0] h;
        logic [6:0] r;
        logic [6:0] p;
        case ($urandom_range(0, 9))
            0:       w = 7'd0;
            1:       w = 7'($urandom_range(1, 7));
            2:       w = 7'($urandom_range(65, 127));
            3:       w = 7'd64;
            8, 9:    w = 7'($urandom_range(33, 64));
            default: w = 7'($urandom_range(8, 32));
        endcase
        case ($urandom_range(0, 9))
            0:       h = 7'd0;
            1:       h = 7'($urandom_range(65, 127));
            2:       h = 7'd64;
            3:       h = 7'd1;
            default: h = 7'($urandom_range(2, 32));
        endcase
        // upper data bits are don't-care for the radius register
        r = {5'($urandom_range(0, 31)), 2'($urandom_range(0, 3))};
        case ($urandom_range(0, 7))
            0:       p = 7'd0;
            1:       p = 7'd127;
            default: p = 7'($urandom_range(1, 126));
        endcase
        set_grid(w, h, r, p);
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // default registers: a splat, its centre and falloff, a second splat on the same
    // centre that saturates, the unused command and a read past the grid
    task automatic test_defaults();
        send_item(CMD_READ, 6'd0, 6'd0);
        send_item(CMD_SPLAT, 6'd10, 6'd10);
        send_item(CMD_READ, 6'd10, 6'd10);
        send_item(CMD_READ, 6'd11, 6'd10);
        send_item(CMD_READ, 6'd13, 6'd13);
        send_item(CMD_SPLAT, 6'd10, 6'd10);
        send_item(CMD_READ, 6'd10, 6'd10);
        send_item(CMD_UNUSED, 6'd63, 6'd63);
        send_item(CMD_READ, 6'd63, 6'd63);
        settle_grid();
    endtask

    // full grid corners, then a one-row grid with the centre off the grid
    task automatic test_edges();
        set_grid(7'd64, 7'd64, 7'd3, 7'd127);
        send_item(CMD_SPLAT, 6'd0, 6'd0);
        send_item(CMD_SPLAT, 6'd63, 6'd63);
        send_item(CMD_READ, 6'd63, 6'd63);
        send_item(CMD_READ, 6'd0, 6'd0);
        settle_grid();
        set_grid(7'd8, 7'd1, 7'd3, 7'd127);
        send_item(CMD_SPLAT, 6'd9, 6'd2);
        send_item(CMD_READ, 6'd7, 6'd0);
        send_item(CMD_READ, 6'd0, 6'd1);
        settle_grid();
    endtask

    // ceiling lowered under a full cell: reads keep it, a touching splat clamps it
    task automatic test_ceiling();
        set_grid(7'd40, 7'd40, 7'd3, 7'd20);
        send_item(CMD_READ, 6'd0, 6'd0);
        send_item(CMD_SPLAT, 6'd2, 6'd2);
        send_item(CMD_READ, 6'd0, 6'd0);
        settle_grid();
    endtask

    // oversized width and height, zero radius and zero peak, then an empty grid
    task automatic test_odd_sizes();
        set_grid(7'd127, 7'd127, 7'd0, 7'd0);
        send_item(CMD_READ, 6'd63, 6'd63);
        send_item(CMD_SPLAT, 6'd63, 6'd63);
        send_item(CMD_READ, 6'd63, 6'd63);
        settle_grid();
        set_grid(7'd0, 7'd0, 7'd1, 7'd64);
        send_item(CMD_SPLAT, 6'd5, 6'd5);
        send_item(CMD_READ, 6'd0, 6'd0);
        send_item(CMD_CLEAR, 6'd0, 6'd0);
        settle_grid();
    endtask

    // one random item: splats at biased centres, reads mostly around recent splats
    task automatic send_random_item();
        int         pick;
        int         slot;
        logic [5:0] col;
        logic [5:0] row;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, 3);
        if (pick < 2)
            send_item(CMD_CLEAR, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        else if (pick < 5)
            send_item(CMD_UNUSED, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        else if (pick < 50)
        begin
            col = pick_coord(cols_in_use());
            row = pick_coord(rows_in_use());
            hot_col[slot] = col;
            hot_row[slot] = row;
            send_item(CMD_SPLAT, col, row);
        end
        else if ($urandom_range(0, 9) < 7)
            send_item(CMD_READ, near_coord(hot_col[slot]), near_coord(hot_row[slot]));
        else
            send_item(CMD_READ, pick_coord(cols_in_use()), pick_coord(rows_in_use()));
    endtask

    // blocks of random items, each under a fresh register set and pacing choice
    task automatic test_random_mix();
        for (int blk = 0; blk < 18; blk++)
        begin
            pick_random_grid();
            pace_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 2) == 0)
                send_item(CMD_CLEAR, 6'd0, 6'd0);
            repeat (100) send_random_item();
            settle_grid();
        end
    endtask

    // closing stretch at full rate on a small dense grid, no idling anywhere
    task automatic test_final_burst();
        pace_on = 1'b0;
        set_grid(7'd16, 7'd16, 7'd3, 7'd127);
        repeat (200) send_random_item();
        settle_grid();
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        cmd        = CMD_CLEAR;
        center_col = '0;
        center_row = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_GRID_WIDTH;
        cfg_data   = '0;
        pace_on    = 1'b1;
        err_count  = 0;
        n_items    = 0;
        n_splats   = 0;
        n_reads    = 0;
        n_clears   = 0;
        n_unused   = 0;
        n_grid_sets = 0;

        // shadow state matches the block after reset
        grid_cols    = RST_GRID_WIDTH;
        grid_rows    = RST_GRID_HEIGHT;
        splat_radius = RST_KERNEL_RADIUS;
        peak         = RST_PEAK_LEVEL;
        wipe_cells();
        foreach (hot_col[i])
        begin
            hot_col[i] = 6'd10;
            hot_row[i] = 6'd10;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // the post-reset clearing pass holds in_ready low; send_item waits it out
        test_defaults();
        test_edges();
        test_ceiling();
        test_odd_sizes();
        test_random_mix();
        test_final_burst();

        // catch any stray beat after the last expected one
        repeat (40) @(posedge clk);

        $display("covered %0d items: %0d splats, %0d reads, %0d clears, %0d unused",
                 n_items, n_splats, n_reads, n_clears, n_unused);
        $display("under %0d register sets incl. zero, one-row and oversized grids",
                 n_grid_sets);
        if (err_count == 0)
            $display("** gaussian_splat_grid: PASSED **");
        else
            $display("** gaussian_splat_grid: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
